// ===== rtl/stpah_pkg.sv =====
// Package for the stepper axis pulse generator with homing.
// Holds beat types, command and register codes and reset constants.
// No dependencies.
`timescale 1ns / 1ps
package stpah_pkg;

	localparam int DistW   = 15;
	localparam int PeriodW = 16;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 16;

	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_MOVE = 2'd1;
	localparam logic [1:0] CMD_HOME = 2'd2;

	localparam logic [1:0] HOME_IDLE    = 2'd0;
	localparam logic [1:0] HOME_SEEK    = 2'd1;
	localparam logic [1:0] HOME_BACKOFF = 2'd2;

	localparam logic [CfgIdxW-1:0] CFG_SEEK_DISTANCE    = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_SEEK_PERIOD      = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_BACKOFF_DISTANCE = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_BACKOFF_PERIOD   = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_HOME_DIRECTION   = 3'd4;

	localparam logic [DistW-1:0]   SEEK_DISTANCE_RST    = 15'd32000;
	localparam logic [PeriodW-1:0] SEEK_PERIOD_RST      = 16'd600;
	localparam logic [DistW-1:0]   BACKOFF_DISTANCE_RST = 15'd4000;
	localparam logic [PeriodW-1:0] BACKOFF_PERIOD_RST   = 16'd400;
	localparam logic               HOME_DIRECTION_RST   = 1'b1;
	localparam logic [PeriodW-1:0] COMPARE_RST          = 16'd400;

	typedef struct packed {
		logic [1:0]         command;
		logic [DistW-1:0]   distance;
		logic [PeriodW-1:0] period;
		logic               direction;
		logic               limit_switch;
	} cmd_beat_t;

	typedef struct packed {
		logic               step_line;
		logic               direction_line;
		logic               running;
		logic [1:0]         home_phase;
		logic [DistW-1:0]   steps_done;
		logic               move_done;
	} res_beat_t;

	typedef struct packed {
		logic [DistW-1:0]   seek_distance;
		logic [PeriodW-1:0] seek_period;
		logic [DistW-1:0]   backoff_distance;
		logic [PeriodW-1:0] backoff_period;
		logic               home_direction;
	} home_cfg_t;

endpackage

// ===== rtl/stpah_axis.sv =====
// Axis state and per-beat update: compare counter, step toggle, step count,
// target and limit stop, homing seek and backoff. Depends on stpah_pkg.
`timescale 1ns / 1ps
module stpah_axis
	import stpah_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      advance,
	input  cmd_beat_t cmd,
	input  home_cfg_t cfg,
	output res_beat_t res
);

	logic               step_level_q;
	logic [DistW-1:0]   step_counter_q;
	logic [DistW-1:0]   target_steps_q;
	logic [PeriodW-1:0] compare_value_q;
	logic [PeriodW-1:0] tick_counter_q;
	logic               dir_level_q;
	logic               enabled_q;
	logic [1:0]         homing_state_q;

	logic               step_level_d;
	logic [DistW-1:0]   step_counter_d;
	logic [DistW-1:0]   target_steps_d;
	logic [PeriodW-1:0] compare_value_d;
	logic [PeriodW-1:0] tick_counter_d;
	logic               dir_level_d;
	logic               enabled_d;
	logic [1:0]         homing_state_d;
	logic               ended;

	always_comb begin
		step_level_d    = step_level_q;
		step_counter_d  = step_counter_q;
		target_steps_d  = target_steps_q;
		compare_value_d = compare_value_q;
		tick_counter_d  = tick_counter_q;
		dir_level_d     = dir_level_q;
		enabled_d       = enabled_q;
		homing_state_d  = homing_state_q;
		ended           = 1'b0;
		case (cmd.command)
			CMD_TICK: begin
				if (enabled_q) begin
					if (tick_counter_q != compare_value_q) begin
						tick_counter_d = tick_counter_q + 16'd1;
					end else begin
						tick_counter_d = '0;
						if (!step_level_q) begin
							step_level_d = 1'b1;
						end else begin
							step_level_d   = 1'b0;
							step_counter_d = step_counter_q + 15'd1;
							if (step_counter_d >= target_steps_q) begin
								homing_state_d = HOME_IDLE;
								step_counter_d = '0;
								enabled_d      = 1'b0;
								ended          = 1'b1;
							end
							if (cmd.limit_switch && homing_state_d != HOME_BACKOFF) begin
								if (enabled_d)
									ended = 1'b1;
								enabled_d      = 1'b0;
								step_counter_d = '0;
								if (homing_state_d == HOME_SEEK) begin
									homing_state_d  = HOME_BACKOFF;
									dir_level_d     = ~cfg.home_direction;
									target_steps_d  = cfg.backoff_distance;
									compare_value_d = cfg.backoff_period;
									tick_counter_d  = '0;
									enabled_d       = 1'b1;
								end
							end
						end
					end
				end
			end
			CMD_MOVE: begin
				dir_level_d     = cmd.direction;
				target_steps_d  = cmd.distance;
				compare_value_d = cmd.period;
				tick_counter_d  = '0;
				enabled_d       = 1'b1;
			end
			CMD_HOME: begin
				homing_state_d  = HOME_SEEK;
				dir_level_d     = cfg.home_direction;
				target_steps_d  = cfg.seek_distance;
				compare_value_d = cfg.seek_period;
				tick_counter_d  = '0;
				enabled_d       = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_level_q    <= 1'b0;
			step_counter_q  <= '0;
			target_steps_q  <= '0;
			compare_value_q <= COMPARE_RST;
			tick_counter_q  <= '0;
			dir_level_q     <= 1'b0;
			enabled_q       <= 1'b0;
			homing_state_q  <= HOME_IDLE;
		end else if (advance) begin
			step_level_q    <= step_level_d;
			step_counter_q  <= step_counter_d;
			target_steps_q  <= target_steps_d;
			compare_value_q <= compare_value_d;
			tick_counter_q  <= tick_counter_d;
			dir_level_q     <= dir_level_d;
			enabled_q       <= enabled_d;
			homing_state_q  <= homing_state_d;
		end
	end

	assign res.step_line      = step_level_d;
	assign res.direction_line = dir_level_d;
	assign res.running        = enabled_d;
	assign res.home_phase     = homing_state_d;
	assign res.steps_done     = step_counter_d;
	assign res.move_done      = ended;

	a_stopped_not_homing: assert property (@(posedge clk) disable iff (!arst_n)
		!enabled_q |-> homing_state_q == HOME_IDLE)
		else $error("axis stopped with homing sequence active");

	a_tick_within_compare: assert property (@(posedge clk) disable iff (!arst_n)
		enabled_q |-> tick_counter_q <= compare_value_q)
		else $error("tick counter passed compare value");

	a_done_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		ended |-> step_counter_d == '0)
		else $error("step count not cleared on stop");

endmodule

// ===== rtl/stepper_axis_pulse_homing.sv =====
// Top level of the stepper axis pulse generator with homing.
// Holds the beat handshake, input and result registers and configuration.
// Depends on stpah_pkg and stpah_axis.
// A command beat is held in the input register; its result beat then goes to the result register.
// One beat per cycle while res_stall does not hold the result; the single-pass axis update allows this.
// Reset (arst_n low): axis stopped, not homing, configuration at its reset values.
`timescale 1ns / 1ps
module stepper_axis_pulse_homing
	import stpah_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  cmd_beat_t           cmd_data,
	output logic                res_valid,
	input  logic                res_stall,
	output res_beat_t           res_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	logic      valid_s1;
	cmd_beat_t cmd_s1;
	logic      res_valid_q;
	res_beat_t res_q;
	res_beat_t res_d;
	home_cfg_t cfg_q;
	logic      advance;
	logic      take;

	assign advance   = valid_s1 && (!res_valid_q || !res_stall);
	assign cmd_stall = valid_s1 && !advance;
	assign take      = cmd_valid && !cmd_stall;
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			cmd_s1 <= cmd_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.seek_distance    <= SEEK_DISTANCE_RST;
			cfg_q.seek_period      <= SEEK_PERIOD_RST;
			cfg_q.backoff_distance <= BACKOFF_DISTANCE_RST;
			cfg_q.backoff_period   <= BACKOFF_PERIOD_RST;
			cfg_q.home_direction   <= HOME_DIRECTION_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SEEK_DISTANCE:    cfg_q.seek_distance    <= cfg_data[DistW-1:0];
				CFG_SEEK_PERIOD:      cfg_q.seek_period      <= cfg_data[PeriodW-1:0];
				CFG_BACKOFF_DISTANCE: cfg_q.backoff_distance <= cfg_data[DistW-1:0];
				CFG_BACKOFF_PERIOD:   cfg_q.backoff_period   <= cfg_data[PeriodW-1:0];
				CFG_HOME_DIRECTION:   cfg_q.home_direction   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	stpah_axis u_axis (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.cmd     (cmd_s1),
		.cfg     (cfg_q),
		.res     (res_d)
	);

	a_advance_fills_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("result register not loaded after advance");

	a_stall_needs_pending: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> valid_s1 && res_valid_q && res_stall)
		else $error("command stalled without a blocked beat");

	a_done_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.move_done |-> res_q.steps_done == '0)
		else $error("result beat reports stop with non-zero step count");

endmodule

// ===== bench/stpah_result_checker.sv =====
// Result checker for the stepper axis pulse generator with homing.
// Watches the command, result and register channels and predicts every result beat.
// Depends on stpah_pkg.
`timescale 1ns / 1ps
module stpah_result_checker
	import stpah_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  logic                cmd_stall,
	input  cmd_beat_t           cmd_data,
	input  logic                res_valid,
	input  logic                res_stall,
	input  res_beat_t           res_data,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	output int                  open_results,
	output int                  fault_count
);

	home_cfg_t          home_cfg;
	logic               axis_step;
	logic [DistW-1:0]   axis_count;
	logic [DistW-1:0]   axis_target;
	logic [PeriodW-1:0] axis_cmp;
	logic [PeriodW-1:0] axis_ticks;
	logic               axis_dir;
	logic               axis_run;
	logic [1:0]         axis_phase;
	res_beat_t          due_results[$];
	int                 faults;

	task automatic reset_axis();
		home_cfg.seek_distance    = SEEK_DISTANCE_RST;
		home_cfg.seek_period      = SEEK_PERIOD_RST;
		home_cfg.backoff_distance = BACKOFF_DISTANCE_RST;
		home_cfg.backoff_period   = BACKOFF_PERIOD_RST;
		home_cfg.home_direction   = HOME_DIRECTION_RST;
		axis_step   = 1'b0;
		axis_count  = '0;
		axis_target = '0;
		axis_cmp    = COMPARE_RST;
		axis_ticks  = '0;
		axis_dir    = 1'b0;
		axis_run    = 1'b0;
		axis_phase  = HOME_IDLE;
	endtask

	task automatic store_setting(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		case (idx)
		CFG_SEEK_DISTANCE:    home_cfg.seek_distance    = val[DistW-1:0];
		CFG_SEEK_PERIOD:      home_cfg.seek_period      = val[PeriodW-1:0];
		CFG_BACKOFF_DISTANCE: home_cfg.backoff_distance = val[DistW-1:0];
		CFG_BACKOFF_PERIOD:   home_cfg.backoff_period   = val[PeriodW-1:0];
		CFG_HOME_DIRECTION:   home_cfg.home_direction   = val[0];
		default: ;
		endcase
	endtask

	task automatic load_move(input logic [DistW-1:0] steps, input logic [PeriodW-1:0] per,
			input logic dir);
		axis_dir    = dir;
		axis_target = steps;
		axis_cmp    = per;
		axis_ticks  = '0;
		axis_run    = 1'b1;
	endtask

	task automatic advance_axis(input cmd_beat_t b, output res_beat_t r);
		logic ended;
		ended = 1'b0;
		case (b.command)
		CMD_TICK: begin
			if (axis_run && axis_ticks != axis_cmp) begin
				axis_ticks = axis_ticks + 16'd1;
			end else if (axis_run && !axis_step) begin
				axis_ticks = '0;
				axis_step  = 1'b1;
			end else if (axis_run) begin
				axis_ticks = '0;
				axis_step  = 1'b0;
				axis_count = axis_count + 15'd1;
				if (axis_count >= axis_target) begin
					axis_phase = HOME_IDLE;
					axis_count = '0;
					axis_run   = 1'b0;
					ended      = 1'b1;
				end
				if (b.limit_switch && axis_phase != HOME_BACKOFF) begin
					if (axis_run)
						ended = 1'b1;
					axis_run   = 1'b0;
					axis_count = '0;
					if (axis_phase == HOME_SEEK) begin
						axis_phase = HOME_BACKOFF;
						load_move(home_cfg.backoff_distance, home_cfg.backoff_period,
							~home_cfg.home_direction);
					end
				end
			end
		end
		CMD_MOVE: load_move(b.distance, b.period, b.direction);
		CMD_HOME: begin
			axis_phase = HOME_SEEK;
			load_move(home_cfg.seek_distance, home_cfg.seek_period, home_cfg.home_direction);
		end
		default: ;
		endcase
		r.step_line      = axis_step;
		r.direction_line = axis_dir;
		r.running        = axis_run;
		r.home_phase     = axis_phase;
		r.steps_done     = axis_count;
		r.move_done      = ended;
	endtask

	task automatic match_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			faults++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		res_beat_t want;
		if (!arst_n) begin
			reset_axis();
			due_results.delete();
			faults = 0;
			open_results <= 0;
			fault_count  <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				store_setting(cfg_index, cfg_data);
			if (res_valid && !res_stall) begin
				if (due_results.size() == 0) begin
					$display("%0t: result beat with none expected, got %h", $time, res_data);
					faults++;
				end else begin
					want = due_results.pop_front();
					match_field("step_line", 16'(want.step_line), 16'(res_data.step_line));
					match_field("direction_line", 16'(want.direction_line),
						16'(res_data.direction_line));
					match_field("running", 16'(want.running), 16'(res_data.running));
					match_field("home_phase", 16'(want.home_phase), 16'(res_data.home_phase));
					match_field("steps_done", 16'(want.steps_done), 16'(res_data.steps_done));
					match_field("move_done", 16'(want.move_done), 16'(res_data.move_done));
				end
			end
			if (cmd_valid && !cmd_stall) begin
				advance_axis(cmd_data, want);
				due_results.push_back(want);
			end
			open_results <= due_results.size();
			fault_count  <= faults;
		end
	end

endmodule

// ===== bench/tb_stepper_axis_pulse_homing.sv =====
// Testbench top for the stepper axis pulse generator with homing.
// Drives command, register and stall traffic; stpah_result_checker does the checking.
// Depends on stpah_pkg, stpah_result_checker and stepper_axis_pulse_homing.
`timescale 1ns / 1ps
module tb_stepper_axis_pulse_homing;
	import stpah_pkg::*;

	localparam logic [1:0] CMD_SPARE = 2'd3;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cmd_valid = 1'b0;
	logic                cmd_stall;
	cmd_beat_t           cmd_data = '0;
	logic                res_valid;
	logic                res_stall = 1'b0;
	res_beat_t           res_data;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_asked = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int beats_sent = 0;
	int open_results;
	int fault_count;

	logic [1:0]         all_codes [4] = '{CMD_TICK, CMD_MOVE, CMD_HOME, CMD_SPARE};
	logic [CfgIdxW-1:0] cfg_order [5] = '{CFG_SEEK_DISTANCE, CFG_SEEK_PERIOD,
		CFG_BACKOFF_DISTANCE, CFG_BACKOFF_PERIOD, CFG_HOME_DIRECTION};

	always #4 clk = ~clk;

	stepper_axis_pulse_homing uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_data  (cmd_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	stpah_result_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.cmd_data     (cmd_data),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.res_data     (res_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.open_results (open_results),
		.fault_count  (fault_count)
	);

	// hold off for a long stretch on request, otherwise stall at random
	always @(posedge clk) begin
		if (hold_left > 0) begin
			res_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_asked) begin
			res_stall <= 1'b1;
			hold_left <= 300;
			hold_seen <= hold_asked;
		end else begin
			res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	function automatic cmd_beat_t random_bits();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[$bits(cmd_beat_t)-1:0];
	endfunction

	task automatic send_beat(input cmd_beat_t b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_data  <= b;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		beats_sent++;
	endtask

	task automatic send_tick(input bit lim);
		cmd_beat_t b;
		b = random_bits();
		b.command      = CMD_TICK;
		b.limit_switch = lim;
		send_beat(b);
	endtask

	task automatic send_start(input logic [1:0] code, input int move_len, input int per,
			input bit dir);
		cmd_beat_t b;
		b = random_bits();
		b.command   = code;
		b.distance  = move_len[DistW-1:0];
		b.period    = per[PeriodW-1:0];
		b.direction = dir;
		send_beat(b);
	endtask

	task automatic settle();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (open_results != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [15:0] sd, input logic [15:0] sp,
			input logic [15:0] bd, input logic [15:0] bp, input logic [15:0] hd);
		logic [15:0] vals [5];
		vals = '{sd, sp, bd, bp, hd};
		for (int i = 0; i < 5; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= cfg_order[i];
			cfg_data  <= vals[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic run_sequence();
		cmd_beat_t b;
		int kind;
		int n;
		int hit_at;
		int move_len;
		int per;
		kind = $urandom_range(0, 99);
		if (kind < 45) begin
			move_len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 32767) :
				$urandom_range(0, 8);
			per = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 3);
			send_start(CMD_MOVE, move_len, per, 1'($urandom_range(0, 1)));
			n = $urandom_range(1, 48);
			repeat (n) send_tick($urandom_range(0, 11) == 0);
		end else if (kind < 75) begin
			send_start(CMD_HOME, $urandom_range(0, 32767), $urandom_range(0, 65535),
				1'($urandom_range(0, 1)));
			n = $urandom_range(4, 80);
			hit_at = $urandom_range(0, n);
			for (int i = 0; i < n; i++)
				send_tick(i >= hit_at);
		end else if (kind < 90) begin
			b = random_bits();
			b.command = all_codes[$urandom_range(0, 3)];
			send_beat(b);
		end else begin
			repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		cmd_beat_t b;
		int stop_at;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: stopped ticks, spare code, field extremes, zero distance and period
		send_tick(1'b1);
		b = '1;
		b.command = CMD_SPARE;
		send_beat(b);
		send_start(CMD_MOVE, 32767, 65535, 1'b1);
		send_tick(1'b1);
		send_start(CMD_MOVE, 0, 0, 1'b0);
		repeat (2) send_tick(1'b0);
		settle();

		// seek hits the switch and backs off; then target and switch on one edge
		apply_settings(16'd3, 16'd1, 16'd2, 16'd0, 16'd0);
		send_start(CMD_HOME, 0, 0, 1'b0);
		repeat (2) send_tick(1'b0);
		repeat (6) send_tick(1'b1);
		send_start(CMD_HOME, 0, 0, 1'b0);
		send_start(CMD_MOVE, 1, 0, 1'b1);
		repeat (2) send_tick(1'b1);

		for (int ph = 0; ph < 8; ph++) begin
			settle();
			case (ph)
			0: apply_settings(16'd3, 16'd1, 16'd2, 16'd0, 16'd0);
			2: apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
			4: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1);
			6: apply_settings(16'd32000, 16'd600, 16'd4000, 16'd400, 16'd1);
			default: apply_settings(16'($urandom_range(1, 12)), 16'($urandom_range(0, 4)),
				16'($urandom_range(0, 6)), 16'($urandom_range(0, 3)),
				16'($urandom_range(0, 1)));
			endcase
			case (ph % 4)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct <= 0;
			end
			1: begin
				send_idle_pct = 74;
				recv_stall_pct <= 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct <= 74;
			end
			default: begin
				send_idle_pct = 17;
				recv_stall_pct <= 17;
			end
			endcase
			if (ph == 0)
				hold_asked <= hold_asked + 1;
			stop_at = beats_sent + 200;
			while (beats_sent < stop_at)
				run_sequence();
		end

		settle();
		repeat (6) @(posedge clk);
		if (fault_count == 0)
			$display("[stepper_axis_pulse_homing] OK");
		else
			$display("[stepper_axis_pulse_homing] ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("[stepper_axis_pulse_homing] ERROR");
		$finish;
	end

endmodule
